@@ src/thpc_pkg.sv @@
package thpc_pkg;

  // Field and datapath widths
  localparam int unsigned TargetW = 14;
  localparam int unsigned TempW   = 16;
  localparam int unsigned LevelW  = 12;
  localparam int unsigned FlowW   = 15;
  localparam int unsigned PowerW  = 34;
  localparam int unsigned ErrW    = 18;   // target - tank, signed
  localparam int unsigned DiffW   = 17;   // temperature differences, signed
  localparam int unsigned KpW     = 33;   // gain numerator, unsigned
  localparam int unsigned FlowKW  = 28;   // flow * 4184, unsigned
  localparam int unsigned QcW     = 49;   // gain * error, unsigned
  localparam int unsigned FlowPW  = 46;   // flow term products, signed
  localparam int unsigned AmbPW   = 38;   // ambient loss product, signed
  localparam int unsigned FfW     = 50;   // feedforward sum, signed
  localparam int unsigned NumW    = 52;   // power numerator over 2^18, signed
  localparam int unsigned FracW   = 18;

  // Constants of the control law
  localparam logic [TargetW-1:0] TargetReset = 14'd6400;
  localparam logic [KpW-1:0]     KpScale     = 33'd1673600;
  localparam logic [KpW-1:0]     KpOffset    = 33'd40960;
  localparam logic [FlowKW-1:0]  WaterHeat   = 28'd4184;
  localparam logic signed [DiffW-1:0] HotTemp  = 17'sd20480;   // 80 degC
  localparam logic signed [AmbPW-1:0] AmbLoss  = 38'sd1024000;
  localparam logic signed [NumW-1:0]  RoundHalf = 52'sd131072;
  localparam logic signed [PowerW-1:0] PowerMax = 34'sd1000000;

  typedef struct packed {
    logic signed [TempW-1:0]  tank_temp;
    logic signed [TempW-1:0]  ambient_temp;
    logic signed [TempW-1:0]  inlet_temp;
    logic        [LevelW-1:0] level;
    logic        [FlowW-1:0]  inlet_flow;
    logic        [FlowW-1:0]  hot_flow;
  } in_item_t;

  typedef struct packed {
    logic signed [PowerW-1:0] heater_power;
    logic                     cooling;
  } out_item_t;

  // Stage 1: error, gain, scaled flows, temperature differences
  typedef struct packed {
    logic                     pos;
    logic [15:0]              err_mag;
    logic [KpW-1:0]           kp;
    logic [FlowKW-1:0]        ni_k;
    logic [FlowKW-1:0]        na_k;
    logic signed [DiffW-1:0]  d_in;
    logic signed [DiffW-1:0]  d_hot;
    logic signed [DiffW-1:0]  d_amb;
  } s1_t;

  // Stage 2: products
  typedef struct packed {
    logic                     pos;
    logic [QcW-1:0]           qc;
    logic signed [FlowPW-1:0] p_in;
    logic signed [FlowPW-1:0] p_hot;
    logic signed [AmbPW-1:0]  p_amb;
  } s2_t;

  // Stage 3: feedforward total
  typedef struct packed {
    logic                  pos;
    logic [QcW-1:0]        qc;
    logic signed [FfW-1:0] ff;
  } s3_t;

  // Stage 4: rounded numerator
  typedef struct packed {
    logic                   pos;
    logic signed [NumW-1:0] num;
  } s4_t;

endpackage

@@ src/thpc_prep.sv @@
module thpc_prep (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic [thpc_pkg::TargetW-1:0]     target_i,
  input  logic                             valid_i,
  input  thpc_pkg::in_item_t               data_i,
  output logic                             valid_o,
  output thpc_pkg::s1_t                    data_o
);

  logic                                   valid_q;
  thpc_pkg::s1_t                          data_q, data_d;
  logic signed [thpc_pkg::ErrW-1:0]       err;

  // Error, gain and differences; constant multiplies only
  always_comb begin
    err = $signed({4'b0, target_i}) - $signed({{2{data_i.tank_temp[15]}}, data_i.tank_temp});
    data_d.pos     = !err[thpc_pkg::ErrW-1] && (err != '0);
    data_d.err_mag = err[15:0];
    data_d.kp      = thpc_pkg::KpW'(data_i.level) * thpc_pkg::KpScale + thpc_pkg::KpOffset;
    data_d.ni_k    = thpc_pkg::FlowKW'(data_i.inlet_flow) * thpc_pkg::WaterHeat;
    data_d.na_k    = thpc_pkg::FlowKW'(data_i.hot_flow) * thpc_pkg::WaterHeat;
    data_d.d_in    = $signed({data_i.inlet_temp[15], data_i.inlet_temp})
                   - $signed({data_i.tank_temp[15], data_i.tank_temp});
    data_d.d_hot   = thpc_pkg::HotTemp - $signed({data_i.tank_temp[15], data_i.tank_temp});
    data_d.d_amb   = $signed({data_i.tank_temp[15], data_i.tank_temp})
                   - $signed({data_i.ambient_temp[15], data_i.ambient_temp});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/thpc_mult.sv @@
module thpc_mult (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  thpc_pkg::s1_t  data_i,
  output logic           valid_o,
  output thpc_pkg::s2_t  data_o
);

  logic           valid_q;
  thpc_pkg::s2_t  data_q, data_d;

  // Four independent products, one multiplier per path
  always_comb begin
    data_d.pos   = data_i.pos;
    data_d.qc    = {16'b0, data_i.kp} * {33'b0, data_i.err_mag};
    data_d.p_in  = $signed({1'b0, data_i.ni_k}) * data_i.d_in;
    data_d.p_hot = $signed({1'b0, data_i.na_k}) * data_i.d_hot;
    data_d.p_amb = data_i.d_amb * thpc_pkg::AmbLoss;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/thpc_sum.sv @@
module thpc_sum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  thpc_pkg::s2_t  data_i,
  output logic           valid_o,
  output thpc_pkg::s4_t  data_o
);

  logic                             valid3_q, valid4_q;
  thpc_pkg::s3_t                    s3_q, s3_d;
  thpc_pkg::s4_t                    s4_q, s4_d;
  logic signed [thpc_pkg::FfW-1:0]  flow_sum;

  // Feedforward: 4 * (inlet + hot) - ambient loss
  always_comb begin
    flow_sum = thpc_pkg::FfW'(data_i.p_in) + thpc_pkg::FfW'(data_i.p_hot);
    s3_d.pos = data_i.pos;
    s3_d.qc  = data_i.qc;
    s3_d.ff  = (flow_sum <<< 2) - thpc_pkg::FfW'(data_i.p_amb);
  end

  // Numerator of the power plus half an LSB for rounding
  always_comb begin
    s4_d.pos = s3_q.pos;
    s4_d.num = $signed({3'b0, s3_q.qc}) - thpc_pkg::NumW'(s3_q.ff) + thpc_pkg::RoundHalf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else if (en_i) begin
      valid3_q <= valid_i;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  assign valid_o = valid4_q;
  assign data_o  = s4_q;

endmodule

@@ src/tank_heater_power_controller_unit.sv @@
// Tank heater power controller: proportional control with loss feedforward.
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one sample set
// per item; output channel (out_valid_o / out_ready_i / out_data_o) returns
// one heater power command and cooling flag per item, in order.
// The target temperature register is written through cfg_we_i / cfg_data_i
// at any clock edge with the write enable high; write it only while idle.
// From input acceptance to output valid an item passes prep, multiply,
// feedforward sum, rounding add and an output stage with saturation.
// Throughput is one item per cycle when not stalled; the four multipliers
// in the multiply stage set the clock, each path one product up to 38x17.
// When the receiver stalls, the whole pipeline holds: in_ready_o drops only
// while the output register holds an item that is not taken, and every
// stage keeps its item or bubble in place, so nothing is lost or repeated.
// Reset clears all valid bits and sets the target to 25 degC (6400).
// A result with a non-positive error is power 0 and cooling 1; otherwise the
// power is rounded to whole watts and limited above at 1000000 W.
module tank_heater_power_controller_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [thpc_pkg::TargetW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  thpc_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output thpc_pkg::out_item_t           out_data_o
);

  logic [thpc_pkg::TargetW-1:0]     target_q;
  logic                             adv;
  logic                             v1, v2, v4;
  thpc_pkg::s1_t                    s1;
  thpc_pkg::s2_t                    s2;
  thpc_pkg::s4_t                    s4;
  logic                             out_valid_q;
  thpc_pkg::out_item_t              out_q, out_d;
  logic signed [thpc_pkg::PowerW-1:0] power;

  // Target temperature register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= thpc_pkg::TargetReset;
    end else if (cfg_we_i) begin
      target_q <= cfg_data_i;
    end
  end

  // Pipeline moves when the output register is empty or being drained
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  thpc_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .target_i (target_q),
    .valid_i  (in_valid_i),
    .data_i   (in_data_i),
    .valid_o  (v1),
    .data_o   (s1)
  );

  thpc_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v1),
    .data_i  (s1),
    .valid_o (v2),
    .data_o  (s2)
  );

  thpc_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2),
    .data_i  (s2),
    .valid_o (v4),
    .data_o  (s4)
  );

  // Floor shift to whole watts, upper saturation, cooling select
  always_comb begin
    power = thpc_pkg::PowerW'(s4.num >>> thpc_pkg::FracW);
    if (!s4.pos) begin
      out_d.heater_power = '0;
      out_d.cooling      = 1'b1;
    end else if (power > thpc_pkg::PowerMax) begin
      out_d.heater_power = thpc_pkg::PowerMax;
      out_d.cooling      = 1'b0;
    end else begin
      out_d.heater_power = power;
      out_d.cooling      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
